FILE: hdl/mbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_pkg: shared types and constants of the mipmap box downsampler
// Image limits, channel layout, register indexes and the result word type.
// ----------------------------------------------------------------------------
package mbd_pkg;

    // widest incoming row and tallest incoming level
    localparam int MAX_WIDTH  = 2048;
    localparam int ROW_LIMIT  = 2048;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);

    // column and row counters, and the clamped sizes one bit wider
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(ROW_LIMIT);
    localparam int EW_W       = COL_W + 1;
    localparam int EH_W       = ROW_W + 1;

    // configuration port
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CMP_W      = (CFG_W > EW_W) ? CFG_W : EW_W;
    localparam int CMPH_W     = (CFG_W > EH_W) ? CFG_W : EH_W;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = CFG_IDX_W'(1);

    localparam int RESET_WIDTH  = 256;
    localparam int RESET_HEIGHT = 256;

    // rgba8 pixel, red in the lowest byte
    localparam int NUM_CH  = 4;
    localparam int CH_W    = 8;
    localparam int PAIR_W  = CH_W + 1;
    localparam int QUAD_W  = CH_W + 2;
    localparam int PIX_W   = NUM_CH * CH_W;
    localparam int LINE_W  = NUM_CH * PAIR_W;

    typedef logic [NUM_CH-1:0][CH_W-1:0]   pixel_t;
    typedef logic [NUM_CH-1:0][PAIR_W-1:0] pair_t;

    typedef struct packed {
        logic   frame_last;
        pixel_t pixel;
    } result_t;

endpackage

FILE: hdl/mbd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_ram: generic simple dual-port ram
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module mbd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/mbd_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_skid: output register with skid stage
// Holds result words for the master side; upstream ready is a register.
// ----------------------------------------------------------------------------
module mbd_skid
    import mbd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_word,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_word_reg, out_word_next;
    result_t skid_word_reg, skid_word_next;
    logic    in_fire, out_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && out_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_fire) begin
            if (!out_valid_reg || out_fire) begin
                out_word_next  = in_word;
                out_valid_next = 1'b1;
            end else begin
                skid_word_next  = in_word;
                skid_valid_next = 1'b1;
            end
        end else if (out_fire) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // the skid stage only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    // once a stalled output word is taken, the skid word moves into the output register
    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && out_ready |=> out_valid_reg && !skid_valid_reg)
        else $error("skid word not forwarded");

endmodule

FILE: hdl/mipmap_box_downsample_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmap_box_downsample_core: 2x2 box-filter mip level reduction
// Averages each aligned 2x2 block of an rgba8 raster into one pixel.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one rgba8 pixel per word in raster order, red in the low byte.
//   m_ channel: one averaged pixel per complete 2x2 block, emitted while the
//   odd row streams in; m_tlast marks the last reduced pixel of the frame.
//   cfg port: source_width (index 0) and source_height (index 1), written only
//   while the block is idle; a trailing odd column or row is dropped.
// throughput
//   one pixel accepted every cycle while s_tready is high; a result is
//   registered once the right-hand pixel of a block on the odd row is
//   accepted. the single line ram's registered read starts on a pair's left pixel.
// reset
//   aresetn clears counters and output valid and sets both sizes to 256;
//   line store contents are not cleared, every entry is written on an even
//   row before its read data is used.
// stall
//   an output register plus a skid word take up a stall; s_tready drops only
//   once both are full and returns the cycle after the receiver takes a word.
// ----------------------------------------------------------------------------
module mipmap_box_downsample_core
    import mbd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIX_W-1:0]     s_tdata,   // red_in, green_in, blue_in, alpha_in
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PIX_W-1:0]     m_tdata,   // red_out, green_out, blue_out, alpha_out
    output logic                 m_tlast    // frame_last
);

    logic [EW_W-1:0]  width_reg, width_next;
    logic [EH_W-1:0]  height_reg, height_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    pixel_t           left_reg, left_next;

    logic [CMP_W-1:0]  cfg_w_wide;
    logic [CMPH_W-1:0] cfg_h_wide;

    pixel_t           pix_in;
    logic             accept;
    logic [EW_W-1:0]  even_w;
    logic [EH_W-1:0]  even_h;
    logic [EW_W-1:0]  x_wide, x_inc;
    logic [EH_W-1:0]  y_wide, y_inc;
    logic             in_range;
    logic             odd_col;
    pair_t            pair;
    pair_t            above;
    logic [LINE_W-1:0] line_rdata;
    logic             line_we, line_re;
    logic [LINE_AW-1:0] slot;
    logic             res_valid, res_ready;
    result_t          res_word, out_word;
    logic [QUAD_W-1:0] quad [NUM_CH];

    // configuration, clamped at write time
    assign cfg_w_wide = CMP_W'(cfg_data);
    assign cfg_h_wide = CMPH_W'(cfg_data);

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH: begin
                    if (cfg_w_wide > CMP_W'(MAX_WIDTH)) begin
                        width_next = EW_W'(MAX_WIDTH);
                    end else if (cfg_w_wide == '0) begin
                        width_next = EW_W'(1);
                    end else begin
                        width_next = EW_W'(cfg_w_wide);
                    end
                end
                REG_SOURCE_HEIGHT: begin
                    if (cfg_h_wide > CMPH_W'(ROW_LIMIT)) begin
                        height_next = EH_W'(ROW_LIMIT);
                    end else if (cfg_h_wide == '0) begin
                        height_next = EH_W'(1);
                    end else begin
                        height_next = EH_W'(cfg_h_wide);
                    end
                end
            endcase
        end
    end

    // pixel datapath
    assign pix_in   = pixel_t'(s_tdata);
    assign accept   = s_tvalid && s_tready;
    assign even_w   = {width_reg[EW_W-1:1], 1'b0};
    assign even_h   = {height_reg[EH_W-1:1], 1'b0};
    assign x_wide   = EW_W'(col_reg);
    assign y_wide   = EH_W'(row_reg);
    assign x_inc    = x_wide + EW_W'(1);
    assign y_inc    = y_wide + EH_W'(1);
    assign in_range = (x_wide < even_w) && (y_wide < even_h);
    assign odd_col  = col_reg[0];
    assign slot     = col_reg[COL_W-1:1];
    assign above    = pair_t'(line_rdata);

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            pair[c] = PAIR_W'(left_reg[c]) + PAIR_W'(pix_in[c]);
            quad[c] = QUAD_W'(above[c]) + QUAD_W'(pair[c]);
            res_word.pixel[c] = quad[c][QUAD_W-1:2];
        end
        res_word.frame_last = (x_wide == even_w - EW_W'(1)) &&
                              (y_wide == even_h - EH_W'(1));
    end

    // left pixel of a pair also launches the line read for the same slot
    assign line_re   = accept && !odd_col;
    assign line_we   = accept && odd_col && in_range && !row_reg[0];
    assign res_valid = accept && odd_col && in_range && row_reg[0];

    always_comb begin
        left_next = left_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (accept) begin
            if (in_range && !odd_col) begin
                left_next = pix_in;
            end
            if (x_inc >= width_reg) begin
                col_next = '0;
                row_next = (y_inc >= height_reg) ? '0 : ROW_W'(y_inc);
            end else begin
                col_next = COL_W'(x_inc);
                if (y_wide >= height_reg) begin
                    row_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= EW_W'(RESET_WIDTH);
            height_reg <= EH_W'(RESET_HEIGHT);
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            left_reg   <= left_next;
        end
    end

    mbd_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (slot),
        .wdata (LINE_W'(pair)),
        .re    (line_re),
        .raddr (slot),
        .rdata (line_rdata)
    );

    mbd_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_word   (res_word),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign s_tready = res_ready;
    assign m_tdata  = PIX_W'(out_word.pixel);
    assign m_tlast  = out_word.frame_last;

    // line writes and results come from rows of opposite parity
    a_write_or_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(line_we && res_valid))
        else $error("line write and result in the same cycle");

    // column advances by one unless it wraps
    a_col_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !cfg_we && (x_inc < width_reg) |=> col_reg == $past(col_next))
        else $error("column counter did not advance");

    // frame end only flagged on a right-hand pixel of an odd row
    a_last_place: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_word.frame_last |-> odd_col && row_reg[0])
        else $error("frame end flagged off a block corner");

endmodule
